FILE: hw/rtl/hsae_pkg.sv
// Shared types, constants and sector tables of the hall sensor angle estimator.
package hsae_pkg;

  localparam int unsigned PERIOD_SLOTS = 6;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned NUM_W        = 17;
  localparam int unsigned DVS_W        = 16;
  localparam int unsigned CNT_W        = 5;

  localparam logic [11:0] STALL_TIMEOUT_RST = 12'd2812;
  localparam logic [14:0] INTERP_LIMIT_RST  = 15'd1013;
  localparam logic [14:0] MOVE_LIMIT_RST    = 15'd1350;
  localparam logic [4:0]  GLITCH_LIMIT_RST  = 5'd30;
  localparam logic [15:0] OFFSET_STOP_RST   = 16'd5916;
  localparam logic [15:0] OFFSET_FWD_RST    = 16'd6735;
  localparam logic [15:0] OFFSET_REV_RST    = 16'd5097;

  localparam logic [14:0] STOPPED_PERIOD = 15'd16872;
  localparam logic [14:0] MIN_PERIOD     = 15'd46;
  localparam logic [15:0] ANGLE_MAX      = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STOP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FWD    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_REV    = 3'd6;

  localparam logic [2:0] SECTOR_MAP [8] = '{3'd0, 3'd2, 3'd4, 3'd3, 3'd6, 3'd1, 3'd5, 3'd0};

  localparam logic [15:0] BASE_ANGLE [6] = '{
    16'd5461, 16'h3FFF, 16'd27306, 16'h9555, 16'hBFFF, 16'hEAAA};

  // per sector: start, low window, high window, plain limit, fast limit
  localparam logic [15:0] FWD_TAB [6][5] = '{
    '{16'd0,     16'hEC16, 16'd5097,  16'd10922, 16'd16019},
    '{16'd10922, 16'd5825, 16'd16019, 16'd21845, 16'd26942},
    '{16'd21845, 16'd16748, 16'd26942, 16'h8000, 16'h93E9},
    '{16'h8000,  16'd27671, 16'h93E9, 16'hAAAA,  16'hBE93},
    '{16'hAAAA,  16'h96C1, 16'hBE93,  16'hD555,  16'hE93E},
    '{16'hD555,  16'hC16C, 16'hE93E,  16'hFFFF,  16'd5097}};

  localparam logic [15:0] REV_TAB [6][5] = '{
    '{16'd10922, 16'd5825, 16'd16019, 16'd0,     16'hEC16},
    '{16'd21845, 16'd16748, 16'd26942, 16'd10922, 16'd5825},
    '{16'h8000,  16'd27671, 16'h93E9, 16'd21845, 16'd16748},
    '{16'hAAAA,  16'h96C1, 16'hBE93,  16'h8000,  16'd27671},
    '{16'hD555,  16'hC16C, 16'hE93E,  16'hAAAA,  16'h96C1},
    '{16'hFFFF,  16'hEC16, 16'd5097,  16'hD555,  16'hC16C}};

  typedef struct packed {
    logic [11:0] stall_timeout;
    logic [14:0] interp_period_limit;
    logic [14:0] move_period_limit;
    logic [4:0]  glitch_limit;
    logic [15:0] offset_stopped;
    logic [15:0] offset_forward;
    logic [15:0] offset_reverse;
  } cfg_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_TICK, CMD_ADV, CMD_EDGE, CMD_SUM,
    CMD_SECTOR, CMD_DIVSET, CMD_DIV, CMD_FIN, CMD_OUT
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_ADV, ST_EDGE, ST_SUM, ST_SECTOR,
    ST_DIVSET, ST_DIV, ST_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic edge_found;  // valid in the advance cycle
    logic sum_needed;  // valid in the edge cycle
    logic sum_last;
    logic div_last;
    logic out_stall;
  } sts_t;

endpackage

FILE: hw/rtl/hsae_intf.sv
// Handshake channel interfaces: hall input, angle result, register writes.
interface hsae_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] hall_bits;
  modport source (output valid, output hall_bits, input ready);
  modport sink   (input valid, input hall_bits, output ready);
endinterface

interface hsae_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle;
  logic [2:0]  sector;
  logic        forward;
  logic        moving_mode;
  logic        position_error;
  logic        pwm_off_request;
  modport source (output valid, output angle, output sector, output forward,
                  output moving_mode, output position_error, output pwm_off_request,
                  input ready);
  modport sink   (input valid, input angle, input sector, input forward,
                  input moving_mode, input position_error, input pwm_off_request,
                  output ready);
endinterface

interface hsae_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/hsae_cfg_regs.sv
// Configuration register file of the angle estimator.
module hsae_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsae_cfg_if.sink     cfg_i,
  output hsae_pkg::cfg_t cfg_o
);
  import hsae_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_STALL_TIMEOUT: cfg_d.stall_timeout       = cfg_i.data[11:0];
        REG_INTERP_LIMIT:  cfg_d.interp_period_limit = cfg_i.data[14:0];
        REG_MOVE_LIMIT:    cfg_d.move_period_limit   = cfg_i.data[14:0];
        REG_GLITCH_LIMIT:  cfg_d.glitch_limit        = cfg_i.data[4:0];
        REG_OFFSET_STOP:   cfg_d.offset_stopped      = cfg_i.data;
        REG_OFFSET_FWD:    cfg_d.offset_forward      = cfg_i.data;
        REG_OFFSET_REV:    cfg_d.offset_reverse      = cfg_i.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stall_timeout       <= STALL_TIMEOUT_RST;
      cfg_q.interp_period_limit <= INTERP_LIMIT_RST;
      cfg_q.move_period_limit   <= MOVE_LIMIT_RST;
      cfg_q.glitch_limit        <= GLITCH_LIMIT_RST;
      cfg_q.offset_stopped      <= OFFSET_STOP_RST;
      cfg_q.offset_forward      <= OFFSET_FWD_RST;
      cfg_q.offset_reverse      <= OFFSET_REV_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/hsae_datapath.sv
// Datapath: tick timing, period store, angle tracking, divider and result register.
module hsae_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hsae_pkg::cfg_t cfg_i,
  input  hsae_pkg::cmd_t cmd_i,
  output hsae_pkg::sts_t sts_o,
  input  logic [2:0]     hall_bits_i,
  hsae_out_if.source     out_o
);
  import hsae_pkg::*;

  // period store, no reset: read only once every slot is written
  logic [11:0] store_q [PERIOD_SLOTS];

  logic [11:0] tick_q, tick_d;
  logic [14:0] six_q, six_d, prev_q, prev_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic full_q, full_d, dir_q, dir_d, last_dir_q, last_dir_d;
  logic [2:0] sector_q, sector_d, last_hall_q, last_hall_d, hall_in_q, hall_q, hall_d;
  logic [4:0] glitch_q, glitch_d;
  logic [2:0] edge_cnt_q, edge_cnt_d;
  logic move_q, move_d, wrap_pend_q, wrap_pend_d, wrapped_q, wrapped_d;
  logic err_q, err_d, pwm_off_q, pwm_off_d;
  logic [15:0] est_q, est_d, step_q, step_d, limit_q, limit_d;
  logic [15:0] next_limit_q, next_limit_d, sec_angle_q, sec_angle_d;
  logic signed [15:0] diff_q, diff_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [NUM_W-1:0] quo_q, quo_d;

  logic        out_valid_q;
  logic [15:0] out_angle_q;
  logic [2:0]  out_sector_q;
  logic        out_fwd_q, out_move_q, out_err_q, out_pwm_q;

  // tick step
  logic [11:0] tick_n;
  // advance step
  logic [15:0] lim_eff;
  logic signed [17:0] c_s, s_s, e_s;
  logic [15:0] est_adv;
  logic [15:0] tick5;
  logic [14:0] tick6;
  // edge step
  logic [2:0] new_sec;
  logic signed [3:0] dsec;
  logic dir_n, clr_n, full_e;
  logic [SLOT_W-1:0] slot_e;
  // sector load
  logic [14:0] six_c;
  logic [2:0]  sidx;
  logic [15:0] t_start, t_lo, t_hi, t_plain, t_fast, diff_u;
  logic        do_snap;
  // divider set-up
  logic signed [17:0] roll, divisor, num;
  // divider step
  logic [DVS_W:0] trial;

  always_comb begin
    tick_n = (tick_q < cfg_i.stall_timeout) ? tick_q + 12'd1 : tick_q;
    tick5  = 16'(tick_q) * 16'd5;
    tick6  = 15'(tick_q) * 15'd6;
    lim_eff = ((six_q > cfg_i.interp_period_limit) ||
               (tick5 >= 16'(cfg_i.interp_period_limit))) ? next_limit_q : limit_q;
    c_s = 18'(lim_eff);
    s_s = 18'(step_q);
    e_s = 18'(est_q);

    new_sec = SECTOR_MAP[hall_q];
    dsec    = $signed({1'b0, new_sec}) - $signed({1'b0, sector_q});
    dir_n   = dir_q;
    if (dsec == 4'sd1 || dsec == -4'sd5) begin
      dir_n = 1'b1;
    end else if (dsec == -4'sd1 || dsec == 4'sd5) begin
      dir_n = 1'b0;
    end
    clr_n  = (last_dir_q != dir_n);
    full_e = clr_n ? 1'b0 : full_q;
    slot_e = clr_n ? '0 : slot_q;

    six_c   = (six_q < MIN_PERIOD) ? MIN_PERIOD : six_q;
    sidx    = sector_q - 3'd1;
    t_start = dir_q ? FWD_TAB[sidx][0] : REV_TAB[sidx][0];
    t_lo    = dir_q ? FWD_TAB[sidx][1] : REV_TAB[sidx][1];
    t_hi    = dir_q ? FWD_TAB[sidx][2] : REV_TAB[sidx][2];
    t_plain = dir_q ? FWD_TAB[sidx][3] : REV_TAB[sidx][3];
    t_fast  = dir_q ? FWD_TAB[sidx][4] : REV_TAB[sidx][4];
    diff_u  = dir_q ? (t_start - est_q) : (est_q - t_start);

    roll    = (six_q <= cfg_i.interp_period_limit) ?
              (18'(six_q) - 18'(prev_q)) : 18'sd0;
    divisor = 18'(six_q) + roll;
    if (divisor < 18'sd1) divisor = 18'sd1;
    num     = 18'(diff_q) + 18'sd65535 + (divisor >>> 1);

    trial = {rem_q, quo_q[NUM_W-1]};
  end

  always_comb begin
    tick_d = tick_q; six_d = six_q; prev_d = prev_q; slot_d = slot_q;
    full_d = full_q; dir_d = dir_q; last_dir_d = last_dir_q; sector_d = sector_q;
    last_hall_d = last_hall_q; hall_d = hall_q; glitch_d = glitch_q;
    edge_cnt_d = edge_cnt_q; move_d = move_q; wrap_pend_d = wrap_pend_q;
    wrapped_d = wrapped_q; err_d = err_q; pwm_off_d = pwm_off_q; est_d = est_q;
    step_d = step_q; limit_d = limit_q; next_limit_d = next_limit_q;
    sec_angle_d = sec_angle_q; diff_d = diff_q; cnt_d = cnt_q;
    rem_d = rem_q; dvs_d = dvs_q; quo_d = quo_q;
    est_adv = est_q;
    do_snap = 1'b0;

    case (cmd_i.op)
      CMD_LOAD: begin
        pwm_off_d = 1'b0;
      end
      CMD_TICK: begin
        tick_d = tick_n;
        if (tick_n >= cfg_i.stall_timeout) begin
          six_d  = STOPPED_PERIOD;
          full_d = 1'b0;
          slot_d = '0;
        end
      end
      CMD_ADV: begin
        limit_d = lim_eff;
        if ((six_q <= cfg_i.move_period_limit) && (tick6 <= cfg_i.move_period_limit)) begin
          if (edge_cnt_q >= 3'd6) move_d = 1'b0;
        end else begin
          move_d     = 1'b1;
          edge_cnt_d = '0;
        end
        if (dir_q) begin
          if (sector_q == 3'd6 && lim_eff != ANGLE_MAX && wrapped_q) begin
            est_adv = (c_s - s_s <= e_s) ? lim_eff : est_q + step_q;
          end else if (sector_q == 3'd6 && lim_eff != ANGLE_MAX) begin
            if (18'sd65535 - s_s < e_s) wrapped_d = 1'b1;
            est_adv = est_q + step_q;
          end else if (wrap_pend_q) begin
            if (18'sd65535 - s_s < e_s) wrap_pend_d = 1'b0;
            est_adv = est_q + step_q;
          end else begin
            est_adv = (c_s - s_s <= e_s) ? lim_eff : est_q + step_q;
          end
        end else begin
          if (sector_q == 3'd1 && lim_eff != 16'd0 && wrapped_q) begin
            est_adv = (c_s + s_s >= e_s) ? lim_eff : est_q - step_q;
          end else if (sector_q == 3'd1 && lim_eff != 16'd0) begin
            if (e_s < s_s) wrapped_d = 1'b1;
            est_adv = est_q - step_q;
          end else if (wrap_pend_q) begin
            if (e_s < s_s) wrap_pend_d = 1'b0;
            est_adv = est_q - step_q;
          end else begin
            est_adv = (c_s + s_s >= e_s) ? lim_eff : est_q - step_q;
          end
        end
        est_d = est_adv;
        // glitch filter on codes 0 and 7
        hall_d = hall_in_q;
        if (hall_in_q != 3'd0 && hall_in_q != 3'd7) begin
          glitch_d = '0;
        end else if (glitch_q < cfg_i.glitch_limit) begin
          glitch_d = glitch_q + 5'd1;
          hall_d   = last_hall_q;
        end
      end
      CMD_EDGE: begin
        wrap_pend_d = 1'b0;
        dir_d       = dir_n;
        last_dir_d  = dir_n;
        if (edge_cnt_q < 3'd6) edge_cnt_d = edge_cnt_q + 3'd1;
        tick_d = '0;
        if (full_e) begin
          six_d = '0;
        end else begin
          // direction change restarts timing from the stopped period
          if (clr_n) begin
            six_d  = STOPPED_PERIOD;
            move_d = 1'b1;
          end else begin
            six_d = 15'(tick_q) * 15'd6;
          end
          if (slot_e == SLOT_W'(PERIOD_SLOTS - 1)) full_d = 1'b1;
          else full_d = 1'b0;
        end
        slot_d      = (slot_e >= SLOT_W'(PERIOD_SLOTS - 1)) ? '0 : slot_e + SLOT_W'(1);
        sector_d    = new_sec;
        last_hall_d = hall_q;
        if (new_sec == 3'd0) begin
          err_d     = 1'b1;
          pwm_off_d = 1'b1;
        end
        cnt_d = '0;
      end
      CMD_SUM: begin
        six_d = six_q + 15'(store_q[cnt_q[SLOT_W-1:0]]);
        cnt_d = cnt_q + CNT_W'(1);
      end
      CMD_SECTOR: begin
        six_d = six_c;
        if (sector_q != 3'd0) begin
          sec_angle_d  = BASE_ANGLE[sidx];
          next_limit_d = t_plain;
          if (dir_q && sector_q == 3'd1 && !wrapped_q) wrap_pend_d = 1'b1;
          if (!dir_q && sector_q == 3'd6 && !wrapped_q) wrap_pend_d = 1'b1;
          diff_d = $signed(diff_u);
          if ((six_c > cfg_i.interp_period_limit) || !full_q) begin
            do_snap = 1'b1;
            limit_d = t_plain;
          end else begin
            limit_d = t_fast;
            if (dir_q && sector_q == 3'd1) begin
              do_snap = wrapped_q ? (est_q > t_hi) : (est_q < t_lo);
            end else if (!dir_q && sector_q == 3'd6) begin
              do_snap = wrapped_q ? (est_q < t_lo) : (est_q > t_hi);
            end else begin
              do_snap = (est_q > t_hi) || (est_q < t_lo);
            end
          end
          if (do_snap) begin
            est_d       = t_start;
            diff_d      = '0;
            wrap_pend_d = 1'b0;
          end
        end
      end
      CMD_DIVSET: begin
        dvs_d = divisor[DVS_W-1:0];
        quo_d = num[NUM_W-1:0];
        rem_d = '0;
        cnt_d = '0;
      end
      CMD_DIV: begin
        if (trial >= {1'b0, dvs_q}) begin
          rem_d = DVS_W'(trial - {1'b0, dvs_q});
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DVS_W-1:0];
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      CMD_FIN: begin
        step_d    = quo_q[NUM_W-1] ? ANGLE_MAX : quo_q[15:0];
        wrapped_d = 1'b0;
        prev_d    = six_q;
      end
      CMD_OUT: begin
        if (move_q) est_d = sec_angle_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_EDGE) store_q[slot_e] <= tick_q;
    if (cmd_i.op == CMD_LOAD) hall_in_q <= hall_bits_i;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    if (cmd_i.op == CMD_OUT) begin
      out_angle_q  <= (move_q ? sec_angle_q : est_q) +
                      (move_q ? cfg_i.offset_stopped :
                       dir_q  ? cfg_i.offset_forward : cfg_i.offset_reverse);
      out_sector_q <= sector_q;
      out_fwd_q    <= dir_q;
      out_move_q   <= move_q;
      out_err_q    <= err_q;
      out_pwm_q    <= pwm_off_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= STALL_TIMEOUT_RST;
      six_q <= '0; prev_q <= '0; slot_q <= '0; full_q <= 1'b0;
      dir_q <= 1'b0; last_dir_q <= 1'b0; sector_q <= '0; last_hall_q <= '0;
      hall_q <= '0; glitch_q <= '0; edge_cnt_q <= '0; move_q <= 1'b0;
      wrap_pend_q <= 1'b0; wrapped_q <= 1'b0; err_q <= 1'b0; pwm_off_q <= 1'b0;
      est_q <= '0; step_q <= '0; limit_q <= '0; next_limit_q <= '0;
      sec_angle_q <= '0; diff_q <= '0; cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tick_q <= tick_d; six_q <= six_d; prev_q <= prev_d; slot_q <= slot_d;
      full_q <= full_d; dir_q <= dir_d; last_dir_q <= last_dir_d; sector_q <= sector_d;
      last_hall_q <= last_hall_d; hall_q <= hall_d; glitch_q <= glitch_d;
      edge_cnt_q <= edge_cnt_d; move_q <= move_d; wrap_pend_q <= wrap_pend_d;
      wrapped_q <= wrapped_d; err_q <= err_d; pwm_off_q <= pwm_off_d; est_q <= est_d;
      step_q <= step_d; limit_q <= limit_d; next_limit_q <= next_limit_d;
      sec_angle_q <= sec_angle_d; diff_q <= diff_d; cnt_q <= cnt_d;
      if (cmd_i.op == CMD_OUT) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.edge_found = (hall_d != last_hall_q);
  assign sts_o.sum_needed = full_e;
  assign sts_o.sum_last   = (cnt_q == CNT_W'(PERIOD_SLOTS - 1));
  assign sts_o.div_last   = (cnt_q == CNT_W'(NUM_W - 1));
  assign sts_o.out_stall  = out_valid_q && !out_o.ready;

  assign out_o.valid           = out_valid_q;
  assign out_o.angle           = out_angle_q;
  assign out_o.sector          = out_sector_q;
  assign out_o.forward         = out_fwd_q;
  assign out_o.moving_mode     = out_move_q;
  assign out_o.position_error  = out_err_q;
  assign out_o.pwm_off_request = out_pwm_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(PERIOD_SLOTS - 1)) else $error("slot index out of range");

  a_pwm_implies_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_pwm_q |-> out_err_q) else $error("pwm off without error flag");

  a_stall_clears_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_TICK) && (tick_n >= cfg_i.stall_timeout) |=> !full_q)
    else $error("stall did not clear period store");

endmodule

FILE: hw/rtl/hsae_ctrl.sv
// Sequencer issuing one command per cycle to the estimator datapath, unless idle or held by a stalled result.
module hsae_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hsae_pkg::sts_t sts_i,
  output hsae_pkg::cmd_t cmd_o
);
  import hsae_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_TICK;
      ST_TICK:   state_d = ST_ADV;
      ST_ADV:    state_d = sts_i.edge_found ? ST_EDGE : ST_OUT;
      ST_EDGE:   state_d = sts_i.sum_needed ? ST_SUM : ST_SECTOR;
      ST_SUM:    if (sts_i.sum_last) state_d = ST_SECTOR;
      ST_SECTOR: state_d = ST_DIVSET;
      ST_DIVSET: state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_last) state_d = ST_FIN;
      ST_FIN:    state_d = ST_OUT;
      ST_OUT:    if (!sts_i.out_stall) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = CMD_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = CMD_LOAD;
      end
      ST_TICK:   cmd_o.op = CMD_TICK;
      ST_ADV:    cmd_o.op = CMD_ADV;
      ST_EDGE:   cmd_o.op = CMD_EDGE;
      ST_SUM:    cmd_o.op = CMD_SUM;
      ST_SECTOR: cmd_o.op = CMD_SECTOR;
      ST_DIVSET: cmd_o.op = CMD_DIVSET;
      ST_DIV:    cmd_o.op = CMD_DIV;
      ST_FIN:    cmd_o.op = CMD_FIN;
      ST_OUT:    if (!sts_i.out_stall) cmd_o.op = CMD_OUT;
      default:   cmd_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/hall_sensor_angle_estimator.sv
// Top level of the hall sensor angle estimator.
//
//  channel  dir  beat contents
//  in_i     in   hall_bits[2:0], one beat per control tick
//  out_o    out  angle, sector, forward, moving_mode, position_error, pwm_off_request
//  cfg_i    in   index[2:0], data[15:0], always ready
//
// A tick without a hall edge runs the tick, advance and output steps after accept; a tick
// with an edge adds the edge step, the six-slot sum once the period store is full, the
// sector load and the 17-step restoring divide.
// Reset is asynchronous, active low; no clearing pass is needed.
// A result stalled on out_o holds the sequencer before it writes the next beat.
module hall_sensor_angle_estimator (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsae_in_if.sink    in_i,
  hsae_out_if.source out_o,
  hsae_cfg_if.sink   cfg_i
);
  import hsae_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file
  hsae_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // sequencer
  hsae_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath with result register
  hsae_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .hall_bits_i (in_i.hall_bits),
    .out_o       (out_o)
  );

endmodule

FILE: bench/hall_sensor_angle_estimator_tb.sv
// Self-checking bench for the hall sensor angle estimator: rotation stimulus and angle prediction.
`timescale 1ns / 100ps

module hall_sensor_angle_estimator_tb;
  import hsae_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS = 320;

  // hall code that produces each sector 1..6
  localparam logic [2:0] SECTOR_HALL [6] = '{3'd5, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4};

  typedef struct packed {
    logic [15:0] angle;
    logic [2:0]  sector;
    logic        forward;
    logic        moving_mode;
    logic        position_error;
    logic        pwm_off_request;
  } angle_beat_t;

  // Angle estimator model plus queue of predicted result beats.
  class angle_scoreboard;
    angle_beat_t pending[$];
    int unsigned mismatches;
    int unsigned failures;

    int unsigned stall_to, interp_lim, move_lim, glitch_lim;
    int unsigned ofs_stop, ofs_fwd, ofs_rev;

    int unsigned tick_cnt, six_per, per_slot[PERIOD_SLOTS], slot;
    bit store_full, edge_seen, dir_fwd, last_dir, move_flag;
    bit wrap_pend, wrapped, err_flag;
    int unsigned cur_sec, last_hall, glitch_cnt, edge_cnt;
    int unsigned est, step, lim, nxt_lim, sec_angle, prev_per;
    int diff;

    function new();
      stall_to = STALL_TIMEOUT_RST; interp_lim = INTERP_LIMIT_RST;
      move_lim = MOVE_LIMIT_RST; glitch_lim = GLITCH_LIMIT_RST;
      ofs_stop = OFFSET_STOP_RST; ofs_fwd = OFFSET_FWD_RST; ofs_rev = OFFSET_REV_RST;
      tick_cnt = stall_to; six_per = 0; slot = 0;
      foreach (per_slot[i]) per_slot[i] = 0;
      store_full = 0; edge_seen = 0; dir_fwd = 0; last_dir = 0; move_flag = 0;
      wrap_pend = 0; wrapped = 0; err_flag = 0;
      cur_sec = 0; last_hall = 0; glitch_cnt = 0; edge_cnt = 0;
      est = 0; step = 0; lim = 0; nxt_lim = 0; sec_angle = 0; prev_per = 0; diff = 0;
      mismatches = 0; failures = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_STALL_TIMEOUT: stall_to   = val[11:0];
        REG_INTERP_LIMIT:  interp_lim = val[14:0];
        REG_MOVE_LIMIT:    move_lim   = val[14:0];
        REG_GLITCH_LIMIT:  glitch_lim = val[4:0];
        REG_OFFSET_STOP:   ofs_stop   = val;
        REG_OFFSET_FWD:    ofs_fwd    = val;
        REG_OFFSET_REV:    ofs_rev    = val;
        default: ;
      endcase
    endfunction

    function void stall_clear();
      six_per = STOPPED_PERIOD; edge_seen = 0; store_full = 0; slot = 0;
    endfunction

    function void snap(int unsigned start);
      est = start; diff = 0; wrap_pend = 0;
    endfunction

    // interpolate one tick, clamped at the sector limit, wrap at 0/65535
    function void advance();
      int c, s, e;
      c = int'(lim); s = int'(step); e = int'(est);
      if (dir_fwd) begin
        if (cur_sec == 6 && lim != 16'hFFFF && wrapped) begin
          if (c - s <= e) est = lim; else est = est + step;
        end else if (cur_sec == 6 && lim != 16'hFFFF) begin
          if (65535 - s < e) wrapped = 1;
          est = est + step;
        end else if (wrap_pend) begin
          if (65535 - s < e) wrap_pend = 0;
          est = est + step;
        end else if (c - s <= e) begin
          est = lim;
        end else begin
          est = est + step;
        end
      end else begin
        if (cur_sec == 1 && lim != 0 && wrapped) begin
          if (c + s >= e) est = lim; else est = est - step;
        end else if (cur_sec == 1 && lim != 0) begin
          if (e < s) wrapped = 1;
          est = est - step;
        end else if (wrap_pend) begin
          if (e < s) wrap_pend = 0;
          est = est - step;
        end else if (c + s >= e) begin
          est = lim;
        end else begin
          est = est - step;
        end
      end
      est = est & 32'hFFFF;
    endfunction

    function void load_sector();
      logic [15:0] start, lo, hi, fast, d16;
      int k;
      k = int'(cur_sec) - 1;
      if (dir_fwd) begin
        start = FWD_TAB[k][0]; lo = FWD_TAB[k][1]; hi = FWD_TAB[k][2];
        nxt_lim = FWD_TAB[k][3]; fast = FWD_TAB[k][4];
      end else begin
        start = REV_TAB[k][0]; lo = REV_TAB[k][1]; hi = REV_TAB[k][2];
        nxt_lim = REV_TAB[k][3]; fast = REV_TAB[k][4];
      end
      sec_angle = BASE_ANGLE[k];
      if (dir_fwd && cur_sec == 1 && !wrapped) wrap_pend = 1;
      if (!dir_fwd && cur_sec == 6 && !wrapped) wrap_pend = 1;
      d16 = dir_fwd ? start - est[15:0] : est[15:0] - start;
      diff = int'($signed(d16));
      if (six_per > interp_lim || !store_full) begin
        snap(start);
        lim = nxt_lim;
        return;
      end
      lim = fast;
      if (dir_fwd && cur_sec == 1) begin
        if (wrapped ? (est > hi) : (est < lo)) snap(start);
      end else if (!dir_fwd && cur_sec == 6) begin
        if (wrapped ? (est < lo) : (est > hi)) snap(start);
      end else if (est > hi || est < lo) begin
        snap(start);
      end
    endfunction

    function bit hall_edge(int unsigned hall);
      bit pwm_off;
      int d, divisor, num, roll;
      int unsigned sum, q;
      pwm_off = 0; roll = 0;
      wrap_pend = 0;
      edge_seen = 1;
      d = int'(SECTOR_MAP[hall]) - int'(cur_sec);
      if (d == 1 || d == -5) dir_fwd = 1;
      else if (d == -1 || d == 5) dir_fwd = 0;
      if (last_dir != dir_fwd) stall_clear();
      last_dir = dir_fwd;
      if (edge_cnt < 6) edge_cnt++;
      per_slot[slot] = tick_cnt;
      tick_cnt = 0;
      if (store_full) begin
        sum = 0;
        foreach (per_slot[i]) sum += per_slot[i];
        six_per = sum;
      end else begin
        if (edge_seen) six_per = PERIOD_SLOTS * per_slot[slot];
        else begin six_per = STOPPED_PERIOD; move_flag = 1; end
        if (slot == PERIOD_SLOTS - 1) store_full = 1;
      end
      slot = (slot >= PERIOD_SLOTS - 1) ? 0 : slot + 1;
      if (six_per < MIN_PERIOD) six_per = MIN_PERIOD;
      cur_sec = SECTOR_MAP[hall];
      last_hall = hall;
      if (cur_sec == 0) begin
        err_flag = 1;
        pwm_off = 1;
      end else begin
        load_sector();
      end
      if (six_per <= interp_lim) roll = int'(six_per) - int'(prev_per);
      divisor = int'(six_per) + roll;
      if (divisor < 1) divisor = 1;
      num = diff + 65535 + divisor / 2;
      q = unsigned'(num) / unsigned'(divisor);
      step = (q > 32'hFFFF) ? 32'hFFFF : q;
      wrapped = 0;
      prev_per = six_per;
      return pwm_off;
    endfunction

    // accepted hall beat: run one control tick and queue the expected result
    function void note_tick(logic [2:0] hall_in);
      int unsigned hall, sum_angle;
      bit pwm_off;
      angle_beat_t exp_beat;
      hall = hall_in; pwm_off = 0;
      if (tick_cnt < stall_to) tick_cnt++;
      if (tick_cnt >= stall_to) stall_clear();
      if (six_per > interp_lim || 5 * tick_cnt >= interp_lim) lim = nxt_lim;
      if (six_per <= move_lim && 6 * tick_cnt <= move_lim) begin
        if (edge_cnt >= 6) move_flag = 0;
      end else begin
        move_flag = 1;
        edge_cnt = 0;
      end
      advance();
      if (hall != 0 && hall != 7) glitch_cnt = 0;
      else if (glitch_cnt < glitch_lim) begin glitch_cnt++; hall = last_hall; end
      if (hall != last_hall) pwm_off = hall_edge(hall);
      if (move_flag) est = sec_angle;
      sum_angle = est + (move_flag ? ofs_stop : dir_fwd ? ofs_fwd : ofs_rev);
      exp_beat.angle = sum_angle[15:0];
      exp_beat.sector = cur_sec[2:0];
      exp_beat.forward = dir_fwd;
      exp_beat.moving_mode = move_flag;
      exp_beat.position_error = err_flag;
      exp_beat.pwm_off_request = pwm_off;
      pending.push_back(exp_beat);
    endfunction

    function void check_beat(angle_beat_t got);
      angle_beat_t want;
      if (pending.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("unexpected result beat %p", got);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      if (got.angle !== want.angle || got.sector !== want.sector ||
          got.forward !== want.forward || got.moving_mode !== want.moving_mode ||
          got.position_error !== want.position_error ||
          got.pwm_off_request !== want.pwm_off_request) begin
        failures++;
        if (mismatches < 10)
          $display("beat mismatch: expected %p, got %p", want, got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  hsae_in_if  in_if();
  hsae_out_if out_if();
  hsae_cfg_if cfg_if();

  hall_sensor_angle_estimator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source),
    .cfg_i  (cfg_if.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  angle_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  bit quiet_tx = 1'b0;   // sender runs back to back
  bit quiet_rx = 1'b0;   // receiver never stalls
  int unsigned beats_sent = 0;
  int unsigned cur_pos = 1;   // sector the rotation stimulus sits in

  initial begin
    in_if.valid = 1'b0;
    in_if.hall_bits = 3'd0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_STALL_TIMEOUT;
    cfg_if.data = 16'd0;
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure, check each accepted beat.
  initial begin : result_sink
    int unsigned hold;
    angle_beat_t got;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.angle, out_if.sector, out_if.forward, out_if.moving_mode,
                out_if.position_error, out_if.pwm_off_request};
        sb.check_beat(got);
      end
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet_rx && $urandom_range(0, 4) == 0) hold = gap_len();
      end
    end
  end

  // One hall beat; valid only drops when a gap follows.
  task automatic send_hall(logic [2:0] hall);
    int unsigned gap;
    in_if.valid <= 1'b1;
    in_if.hall_bits <= hall;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(hall);
    beats_sent++;
    gap = quiet_tx ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; only called once the block has gone quiet.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] st, logic [15:0] il, logic [15:0] ml,
                           logic [15:0] gl, logic [15:0] os, logic [15:0] of,
                           logic [15:0] orv);
    write_reg(REG_STALL_TIMEOUT, st);
    write_reg(REG_INTERP_LIMIT, il);
    write_reg(REG_MOVE_LIMIT, ml);
    write_reg(REG_GLITCH_LIMIT, gl);
    write_reg(REG_OFFSET_STOP, os);
    write_reg(REG_OFFSET_FWD, of);
    write_reg(REG_OFFSET_REV, orv);
  endtask

  // Random part: mostly clean rotations with random dwell, direction flips and
  // short glitches; the rest plain noise on the hall lines.
  task automatic random_phase(int unsigned n_items);
    int unsigned target, dwell, n_steps, pick;
    bit fwd;
    target = beats_sent + n_items;
    fwd = $urandom_range(0, 1);
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (beats_sent > target - n_items / 2 && beats_sent < target - n_items / 2 + 8)
        drain();   // sender holds off until the block has caught up
      if (pick < 85) begin
        if ($urandom_range(0, 3) == 0) fwd = !fwd;
        dwell = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                            : $urandom_range(1, 25);
        n_steps = $urandom_range(6, 18);
        repeat (n_steps) begin
          if (beats_sent >= target) break;
          cur_pos = fwd ? (cur_pos % 6) + 1 : ((cur_pos + 4) % 6) + 1;
          repeat ($urandom_range(dwell > 2 ? dwell - 2 : 1, dwell + 2)) begin
            if (beats_sent >= target) break;
            if ($urandom_range(0, 29) == 0)
              repeat ($urandom_range(1, 4)) send_hall($urandom_range(0, 1) ? 3'd7 : 3'd0);
            send_hall(SECTOR_HALL[cur_pos - 1]);
          end
        end
      end else begin
        repeat ($urandom_range(1, 12)) send_hall(3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every hall code including both invalid ones, a fast forward
    // turn, a reverse turn, a skipped sector and a short invalid run.
    for (int h = 0; h < 8; h++) send_hall(h[2:0]);
    for (int s = 1; s <= 6; s++) send_hall(SECTOR_HALL[s - 1]);
    for (int s = 6; s >= 1; s--) send_hall(SECTOR_HALL[s - 1]);
    send_hall(SECTOR_HALL[3]);          // unknown jump keeps direction
    send_hall(3'd7);
    send_hall(3'd0);
    send_hall(3'd7);
    drain();

    // Phases: reset values, upper extremes, lower extremes, a tuned set, random.
    for (phase_no = 0; phase_no < 5; phase_no++) begin
      quiet_tx = (phase_no == 2);
      quiet_rx = (phase_no == 3);
      case (phase_no)
        1: write_all(16'd4095, 16'd32767, 16'd32767, 16'd31, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_all(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        3: write_all(16'd60, 16'd400, 16'd500, 16'd3, 16'($urandom), 16'($urandom),
                     16'($urandom));
        4: begin
          write_all(16'($urandom_range(1, 4095)), 16'($urandom_range(0, 2000)),
                    16'($urandom_range(0, 2000)), 16'($urandom_range(0, 31)),
                    16'($urandom), 16'($urandom), 16'($urandom));
          write_reg(3'd7, 16'($urandom));    // unused index, must be ignored
        end
        default: ;
      endcase
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (sb.pending.size() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hsae_pkg.sv
hw/rtl/hsae_intf.sv
hw/rtl/hsae_cfg_regs.sv
hw/rtl/hsae_datapath.sv
hw/rtl/hsae_ctrl.sv
hw/rtl/hall_sensor_angle_estimator.sv
bench/hall_sensor_angle_estimator_tb.sv
